### rtl/core/ltpt_pkg.sv
// Types, codes and fixed-point helpers for the L-system turtle path tracer.
// No dependencies; imported by the top level.
package ltpt_pkg;

  typedef struct packed {
    logic               func;
    logic        [7:0]  symbol;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic        [30:0] step_size;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               stack_overflow;
  } out_word_t;

  // saved turtle entry: position then step vector
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } turtle_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BEGIN,
    OP_FWD,
    OP_ROT_P,
    OP_ROT_M,
    OP_PUSH,
    OP_POP
  } op_t;

  localparam logic       FUNC_BEGIN = 1'b0;

  localparam logic [7:0] SYM_FWD    = 8'h46;  // 'F'
  localparam logic [7:0] SYM_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] SYM_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] SYM_PUSH   = 8'h5B;  // '['
  localparam logic [7:0] SYM_POP    = 8'h5D;  // ']'

  // cos(30 deg) in Q2.30; sin(30 deg) is exactly 2^29 and becomes a shift
  localparam logic signed [31:0] COS30_Q30 = 32'sd929887697;

  localparam logic signed [63:0] RND30 = 64'sd536870912;  // 2^29
  localparam logic signed [63:0] RND15 = 64'sd16384;      // 2^14

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else                r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/ltpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ltpt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lsystem_turtle_path_tracer_top.sv
// L-system turtle path tracer, 2D, Q24.8 coordinates. Uses ltpt_pkg, ltpt_ram.
// A begin or 'F' word is decoded on acceptance, then waits in the execute stage for
//   a free output register (one decode stage, one execute stage writing out_*).
// Throughput: one word per cycle for any symbol mix, bounded only by out_ready;
//   pops read the stack RAM in the decode cycle; its registered output feeds execute.
// Reset (rst_n low, synchronous): turtle zero, stack empty, overflow clear, no word held.
//   The stack RAM needs no clearing pass; entries are only read after being pushed.
module lsystem_turtle_path_tracer_top
  import ltpt_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // ---------------------------------------------------------------
  // Decode stage: stack pointer and overflow flag live here, since
  // they depend only on the symbol sequence. The RAM read for a pop
  // is issued now so data is ready when the word executes.
  // ---------------------------------------------------------------
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          in_fire;
  op_t           a_op;
  logic          push_ok, pop_ok;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] rd_addr;

  assign push_ok  = count_r < CW'(STACK_DEPTH);
  assign pop_ok   = count_r != '0;
  assign count_m1 = count_r - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];

  always_comb begin
    if (in_data.func == FUNC_BEGIN) begin
      a_op = OP_BEGIN;
    end else begin
      unique case (in_data.symbol)
        SYM_FWD:   a_op = OP_FWD;
        SYM_PLUS:  a_op = OP_ROT_P;
        SYM_MINUS: a_op = OP_ROT_M;
        SYM_PUSH:  a_op = push_ok ? OP_PUSH : OP_NOP;
        SYM_POP:   a_op = pop_ok ? OP_POP : OP_NOP;
        default:   a_op = OP_NOP;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (in_fire) begin
      if (a_op == OP_BEGIN) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (a_op == OP_PUSH) begin
        count_nxt = count_r + CW'(1);
      end else if (a_op == OP_POP) begin
        count_nxt = count_m1;
      end else if (in_data.symbol == SYM_PUSH) begin
        ovf_nxt = 1'b1;  // push onto a full stack is dropped
      end
    end
  end

  // ---------------------------------------------------------------
  // Execute stage register
  // ---------------------------------------------------------------
  logic               b_valid_r;
  op_t                b_op_r;
  logic signed [31:0] b_sx_r, b_sy_r;
  logic signed [15:0] b_dx_r, b_dy_r;
  logic        [30:0] b_len_r;
  logic               b_ovf_r;   // sticky flag as seen after this word
  logic [AW-1:0]      b_waddr_r;
  logic               out_valid_r;

  logic b_emits, b_fire, out_free;

  assign b_emits  = (b_op_r == OP_BEGIN) || (b_op_r == OP_FWD);
  assign out_free = !out_valid_r || out_ready;
  assign b_fire   = b_valid_r && (!b_emits || out_free);
  assign in_ready = !b_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------
  // Turtle state
  // ---------------------------------------------------------------
  logic signed [31:0] pos_x_r, pos_y_r, vec_x_r, vec_y_r;
  logic signed [31:0] pos_x_nxt, pos_y_nxt, vec_x_nxt, vec_y_nxt;

  // ---------------------------------------------------------------
  // Stack RAM with same-cycle forwarding. A push executing while the
  // very next word (a pop) is decoded hits the same entry; the RAM
  // read misses that write, so the written entry is captured here.
  // ---------------------------------------------------------------
  logic    ram_we, ram_re, fwd_hit;
  turtle_t wr_entry, rd_entry, pop_entry;
  turtle_t fwd_data_r;
  logic    fwd_sel_r;

  assign wr_entry = '{px: pos_x_r, py: pos_y_r, vx: vec_x_r, vy: vec_y_r};
  assign ram_we   = b_fire && (b_op_r == OP_PUSH);
  assign ram_re   = in_fire && (a_op == OP_POP);
  assign fwd_hit  = ram_we && (b_waddr_r == rd_addr);

  ltpt_ram #(
    .WIDTH ($bits(turtle_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr_r),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  assign pop_entry = fwd_sel_r ? fwd_data_r : rd_entry;

  always_ff @(posedge clk) begin
    if (ram_re) begin
      fwd_sel_r  <= fwd_hit;
      fwd_data_r <= wr_entry;
    end
  end

  // ---------------------------------------------------------------
  // Datapath: begin scaling, rotation, forward step
  // ---------------------------------------------------------------
  logic signed [63:0] beg_px, beg_py;     // dir * step_size, Q.23
  logic signed [63:0] rot_xc, rot_yc;     // component * cos30, Q.38
  logic signed [63:0] rot_xs, rot_ys;     // component * sin30 (shift by 29)
  logic signed [63:0] rot_nx, rot_ny;
  logic signed [32:0] fwd_sx, fwd_sy;
  logic signed [31:0] beg_vx, beg_vy, rot_vx, rot_vy, fwd_x, fwd_y;

  always_comb begin
    beg_px = 64'(b_dx_r) * 64'(signed'({1'b0, b_len_r}));
    beg_py = 64'(b_dy_r) * 64'(signed'({1'b0, b_len_r}));
    beg_vx = sat32((beg_px + RND15) >>> 15);
    beg_vy = sat32((beg_py + RND15) >>> 15);

    rot_xc = 64'(vec_x_r) * 64'(COS30_Q30);
    rot_yc = 64'(vec_y_r) * 64'(COS30_Q30);
    rot_xs = {{3{vec_x_r[31]}}, vec_x_r, 29'b0};
    rot_ys = {{3{vec_y_r[31]}}, vec_y_r, 29'b0};
    if (b_op_r == OP_ROT_M) begin
      rot_nx = rot_xc + rot_ys;
      rot_ny = rot_yc - rot_xs;
    end else begin
      rot_nx = rot_xc - rot_ys;
      rot_ny = rot_yc + rot_xs;
    end
    rot_vx = sat32((rot_nx + RND30) >>> 30);
    rot_vy = sat32((rot_ny + RND30) >>> 30);

    fwd_sx = {pos_x_r[31], pos_x_r} + {vec_x_r[31], vec_x_r};
    fwd_sy = {pos_y_r[31], pos_y_r} + {vec_y_r[31], vec_y_r};
    fwd_x  = sat33(fwd_sx);
    fwd_y  = sat33(fwd_sy);
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vec_x_nxt = vec_x_r;
    vec_y_nxt = vec_y_r;
    if (b_fire) begin
      case (b_op_r)
        OP_BEGIN: begin
          pos_x_nxt = b_sx_r;
          pos_y_nxt = b_sy_r;
          vec_x_nxt = beg_vx;
          vec_y_nxt = beg_vy;
        end
        OP_FWD: begin
          pos_x_nxt = fwd_x;
          pos_y_nxt = fwd_y;
        end
        OP_ROT_P, OP_ROT_M: begin
          vec_x_nxt = rot_vx;
          vec_y_nxt = rot_vy;
        end
        OP_POP: begin
          pos_x_nxt = pop_entry.px;
          pos_y_nxt = pop_entry.py;
          vec_x_nxt = pop_entry.vx;
          vec_y_nxt = pop_entry.vy;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  out_word_t out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      b_valid_r   <= 1'b0;
      b_op_r      <= OP_NOP;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vec_x_r     <= '0;
      vec_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vec_x_r <= vec_x_nxt;
      vec_y_r <= vec_y_nxt;
      if (in_ready) begin
        b_valid_r <= in_valid;
        b_op_r    <= a_op;
      end
      if (b_fire && b_emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_sx_r    <= in_data.start_x;
      b_sy_r    <= in_data.start_y;
      b_dx_r    <= in_data.dir_x;
      b_dy_r    <= in_data.dir_y;
      b_len_r   <= in_data.step_size;
      b_ovf_r   <= ovf_nxt;
      b_waddr_r <= count_r[AW-1:0];
    end
    if (b_fire && b_emits) begin
      out_data_r.point_x        <= pos_x_nxt;
      out_data_r.point_y        <= pos_y_nxt;
      out_data_r.stack_overflow <= (b_op_r == OP_BEGIN) ? 1'b0 : b_ovf_r;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.func == FUNC_BEGIN) |=> (count_r == '0) && !ovf_r)
    else $error("begin did not empty stack / clear overflow");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && !(in_fire && (in_data.func == FUNC_BEGIN)) |=> ovf_r)
    else $error("overflow flag dropped without begin");

  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_emits && out_valid_r && !out_ready |=> b_valid_r && $stable(b_op_r))
    else $error("emitting word lost while output stalled");

endmodule

### sim/tb_turtle_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the turtle path tracer: a fixed-point turtle that predicts
// every emitted point and checks the block's output words against it.
// Depends on ltpt_pkg for the word types and symbol codes.
package tb_turtle_pkg;
  import ltpt_pkg::*;

  localparam int     STACK_SLOTS  = 64;
  localparam longint COS30_SCALED = 929887697;  // cos(30 deg) * 2^30
  localparam longint SIN30_SCALED = 536870912;  // sin(30 deg) * 2^30

  class turtle_scoreboard;
    logic signed [31:0] pos_x, pos_y, vec_x, vec_y;
    turtle_t            saved [STACK_SLOTS];
    int unsigned        depth;
    logic               overflow;
    out_word_t          expected_points [$];
    int                 errors;

    function new();
      pos_x    = '0;
      pos_y    = '0;
      vec_x    = '0;
      vec_y    = '0;
      depth    = 0;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    static function logic signed [31:0] clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // round half toward +inf, then arithmetic shift
    static function longint round_shift(longint v, int unsigned s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function void rotate_step(bit ccw);
      longint s, nx, ny;
      s  = ccw ? SIN30_SCALED : -SIN30_SCALED;
      nx = longint'(vec_x) * COS30_SCALED - longint'(vec_y) * s;
      ny = longint'(vec_x) * s + longint'(vec_y) * COS30_SCALED;
      vec_x = clamp32(round_shift(nx, 30));
      vec_y = clamp32(round_shift(ny, 30));
    endfunction

    function void track_word(in_word_t w);
      longint    len;
      bit        emits;
      out_word_t next_pt;
      len   = longint'(w.step_size);
      emits = 1'b0;
      if (w.func == FUNC_BEGIN) begin
        pos_x    = w.start_x;
        pos_y    = w.start_y;
        vec_x    = clamp32(round_shift(longint'($signed(w.dir_x)) * len, 15));
        vec_y    = clamp32(round_shift(longint'($signed(w.dir_y)) * len, 15));
        depth    = 0;
        overflow = 1'b0;
        emits    = 1'b1;
      end else begin
        case (w.symbol)
          SYM_FWD: begin
            pos_x = clamp32(longint'(pos_x) + longint'(vec_x));
            pos_y = clamp32(longint'(pos_y) + longint'(vec_y));
            emits = 1'b1;
          end
          SYM_PLUS:  rotate_step(1'b1);
          SYM_MINUS: rotate_step(1'b0);
          SYM_PUSH: begin
            if (depth < STACK_SLOTS) begin
              saved[depth] = '{px: pos_x, py: pos_y, vx: vec_x, vy: vec_y};
              depth++;
            end else begin
              overflow = 1'b1;
            end
          end
          SYM_POP: begin
            if (depth > 0) begin
              depth--;
              pos_x = saved[depth].px;
              pos_y = saved[depth].py;
              vec_x = saved[depth].vx;
              vec_y = saved[depth].vy;
            end
          end
          default: ;
        endcase
      end
      if (emits) begin
        next_pt = '{point_x: pos_x, point_y: pos_y, stack_overflow: overflow};
        expected_points = {expected_points, next_pt};
      end
    endfunction

    function void flag(string field, logic signed [31:0] want_v, logic signed [31:0] got_v);
      errors++;
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    endfunction

    function void check_point(out_word_t got);
      out_word_t want;
      if (expected_points.size() == 0) begin
        errors++;
        $error("point (%0d, %0d) arrived with none expected", got.point_x, got.point_y);
        return;
      end
      want = expected_points.pop_front();
      if (got.point_x !== want.point_x) flag("point_x", want.point_x, got.point_x);
      if (got.point_y !== want.point_y) flag("point_y", want.point_y, got.point_y);
      if (got.stack_overflow !== want.stack_overflow)
        flag("stack_overflow", want.stack_overflow, got.stack_overflow);
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for lsystem_turtle_path_tracer_top: directed and random
// turtle strings with random idling on both sides. Uses ltpt_pkg, tb_turtle_pkg.
module tb_top;
  import ltpt_pkg::*;
  import tb_turtle_pkg::*;

  localparam logic FUNC_SYMBOL  = 1'b1;
  localparam int   WORDS_WANTED = 900;   // words in the random part
  localparam int   HOLD_AT      = 250;   // receiver backs off once this many sent
  localparam int   HOLD_CYCLES  = 120;
  localparam int   QUIET_FROM   = 450;   // no idling on either side in this window
  localparam int   QUIET_TO     = 600;
  localparam int   DRAIN_LIMIT  = 5000;
  localparam int   SETTLE       = 8;     // pipeline is two stages deep

  // direction table for 30 degree multiples, Q1.15; sin(k) is cos(k - 90)
  localparam logic signed [15:0] UNIT_COS [12] = '{
    16'sd32767, 16'sd28378, 16'sd16384, 16'sd0, -16'sd16384, -16'sd28378,
    -16'sd32768, -16'sd28378, -16'sd16384, 16'sd0, 16'sd16384, 16'sd28378
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  turtle_scoreboard sb;
  int               words_sent;  // words accepted so far

  always #2 clk = ~clk;

  lsystem_turtle_path_tracer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Both handshakes are observed at the rising edge, before the block's
  // registers update; the testbench only drives on the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.track_word(in_data);
      if (out_valid && out_ready) sb.check_point(out_data);
    end
  end

  function automatic bit quiet_now();
    return words_sent >= QUIET_FROM && words_sent < QUIET_TO;
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    while (!quiet_now() && $urandom_range(99) < 16) @(negedge clk);
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    words_sent++;
  endtask

  // Fields that a word does not use carry random noise.
  function automatic in_word_t begin_word(input logic signed [31:0] sx,
                                          input logic signed [31:0] sy,
                                          input logic signed [15:0] dx,
                                          input logic signed [15:0] dy,
                                          input logic [30:0]        len);
    in_word_t w;
    w.func      = FUNC_BEGIN;
    w.symbol    = 8'($urandom());
    w.start_x   = sx;
    w.start_y   = sy;
    w.dir_x     = dx;
    w.dir_y     = dy;
    w.step_size = len;
    return w;
  endfunction

  function automatic in_word_t symbol_word(input logic [7:0] s);
    in_word_t w;
    w.func      = FUNC_SYMBOL;
    w.symbol    = s;
    w.start_x   = 32'($urandom());
    w.start_y   = 32'($urandom());
    w.dir_x     = 16'($urandom());
    w.dir_y     = 16'($urandom());
    w.step_size = 31'($urandom());
    return w;
  endfunction

  // Mostly turtle commands, with some stray bytes that the block ignores.
  function automatic logic [7:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 34) return SYM_FWD;
    if (r < 49) return SYM_PLUS;
    if (r < 64) return SYM_MINUS;
    if (r < 76) return SYM_PUSH;
    if (r < 88) return SYM_POP;
    return 8'($urandom());
  endfunction

  task automatic send_random_begin();
    logic signed [31:0] sx, sy;
    logic signed [15:0] dx, dy;
    logic [30:0]        len;
    int unsigned        k;
    sx = 32'($urandom());
    sy = 32'($urandom());
    // keep most paths clear of the coordinate rails
    if ($urandom_range(3) != 0) begin
      sx = sx >>> 10;
      sy = sy >>> 10;
    end else if ($urandom_range(1) == 0) begin
      sx = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    if ($urandom_range(1) == 0) begin
      k  = $urandom_range(11);
      dx = UNIT_COS[k];
      dy = UNIT_COS[(k + 9) % 12];
    end else begin
      dx = 16'($urandom());
      dy = 16'($urandom());
    end
    len = ($urandom_range(3) != 0) ? 31'($urandom_range(0, 16384)) : 31'($urandom());
    send_word(begin_word(sx, sy, dx, dy, len));
  endtask

  // Receiver: random stalls, one long hold-off so the pipe backs up into
  // in_ready, and a window with out_ready held high.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = quiet_now() || $urandom_range(99) >= 16;
      end
    end
  end

  initial begin
    int guard;
    int unsigned nest;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    words_sent  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Symbols ahead of any begin act on the zeroed turtle.
    send_word(symbol_word(SYM_FWD));
    send_word(symbol_word(SYM_PLUS));
    send_word(symbol_word(SYM_POP));       // pop on an empty stack is ignored
    send_word(symbol_word(SYM_FWD));
    // Extreme start and longest step: F then saturates both coordinates,
    // and the rotation pushes x of the step vector past the rail.
    send_word(begin_word(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000,
                         31'h7FFF_FFFF));
    send_word(symbol_word(SYM_FWD));
    send_word(symbol_word(SYM_PLUS));
    send_word(symbol_word(SYM_MINUS));
    send_word(symbol_word(SYM_FWD));
    // Half-unit products: +0.5 rounds up to 1, -0.5 rounds up to 0.
    send_word(begin_word(32'sd0, 32'sd0, 16'sd1, -16'sd1, 31'd16384));
    send_word(symbol_word(SYM_FWD));
    // Save, wander off, restore.
    send_word(symbol_word(SYM_PUSH));
    send_word(symbol_word(SYM_FWD));
    send_word(symbol_word(SYM_MINUS));
    send_word(symbol_word(SYM_FWD));
    send_word(symbol_word(SYM_POP));
    send_word(symbol_word(SYM_FWD));
    send_word(symbol_word(8'h00));         // stray bytes do nothing
    send_word(symbol_word(8'hFF));
    // Zero step length, then a unit heading rotated once.
    send_word(begin_word(-32'sd1, 32'sd1, -16'sd32768, 16'sd0, 31'd0));
    send_word(symbol_word(SYM_FWD));
    send_word(begin_word(32'sd0, 32'sd0, 16'sd0, 16'sd32767, 31'd256));
    send_word(symbol_word(SYM_PLUS));
    send_word(symbol_word(SYM_FWD));

    // Random paths: each begins a fresh turtle and runs a random string.
    // About one in eight nests 60 to 70 pushes deep, which can run off the 64-entry stack.
    words_sent = 0;
    while (words_sent < WORDS_WANTED) begin
      send_random_begin();
      if ($urandom_range(7) == 0) begin
        nest = $urandom_range(60, 70);
        repeat (nest) begin
          send_word(symbol_word(SYM_PUSH));
          if ($urandom_range(3) == 0) send_word(symbol_word(pick_symbol()));
        end
        send_word(symbol_word(SYM_FWD));
        repeat ($urandom_range(10, 70)) begin
          send_word(symbol_word(SYM_POP));
          if ($urandom_range(2) == 0) send_word(symbol_word(SYM_FWD));
        end
      end else begin
        repeat ($urandom_range(4, 40)) send_word(symbol_word(pick_symbol()));
      end
    end

    // Drain, then let the pipe settle so that any stray word shows.
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected points never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### files.f
rtl/core/ltpt_pkg.sv
rtl/core/ltpt_ram.sv
rtl/core/lsystem_turtle_path_tracer_top.sv
sim/tb_turtle_pkg.sv
sim/tb_top.sv
